// ----- rtl/lav_pkg.sv -----
`timescale 1ns / 1ps
package lav_pkg;

   // Fixed point format of all vector entries
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   // Unit vector entries lie in [-2^FRAC_BITS, 2^FRAC_BITS]
   localparam int UNIT_W    = FRAC_BITS + 2;
   // Cross products and raw differences
   localparam int CROSS_W   = FRAC_BITS + 34;
   // Dot product sums
   localparam int DOT_W     = CROSS_W + 2;

   // Row codes
   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd2;

   typedef logic signed [WORD_W-1:0]  word_type;
   typedef logic signed [UNIT_W-1:0]  unit_type;
   typedef logic signed [CROSS_W-1:0] wide_type;

   typedef word_type [2:0] wvec_type;
   typedef unit_type [2:0] uvec_type;
   typedef wide_type [2:0] cvec_type;

   localparam word_type WORD_ONE = word_type'(1) << FRAC_BITS;
   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // Everything a request carries between the math units
   typedef struct packed {
      wvec_type eye;
      wvec_type up;
      uvec_type f;
      uvec_type r;
      logic     deg;
   } side_type;

   typedef logic [3:0][WORD_W-1:0] row_type;
   typedef row_type [2:0]          mat_type;

endpackage

// ----- rtl/lav_unit.sv -----
`timescale 1ns / 1ps
module lav_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  lav_pkg::cvec_type  in_vec,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::uvec_type  out_vec,
   output logic               out_zero,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   localparam int MW      = 30;
   localparam int SQ_W    = 2 * MW;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 4;
   localparam int NUM_W   = MW + FRAC_BITS + 1;
   localparam int DREM_W  = ROOT_W + 1;
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int NRM_STG = $clog2(CROSS_W);
   localparam int SQT_STG = (ROOT_W + 1) / 2;
   localparam int DIV_STG = (QUO_W + 1) / 2;
   localparam int S_SQR   = NRM_STG + 1;
   localparam int S_SUM   = S_SQR + 1;
   localparam int S_SQT   = S_SUM + 1;
   localparam int S_PRE   = S_SQT + SQT_STG;
   localparam int S_DIV   = S_PRE + 1;
   localparam int S_FIN   = S_DIV + DIV_STG;
   localparam int N_STG   = S_FIN + 1;

   typedef struct packed {
      side_type                     side;
      logic [2:0]                   neg;
      logic                         zero;
      logic [2:0][CROSS_W-1:0]      mag;
      logic [2:0][SQ_W-1:0]         sq;
      logic [SUM_W-1:0]             sum;
      logic [REM_W-1:0]             srem;
      logic [ROOT_W-1:0]            root;
      logic [2:0][NUM_W-1:0]        num;
      logic [2:0][DREM_W-1:0]       drem;
      logic [2:0][QUO_W-1:0]        quo;
      uvec_type                     u;
   } lane_type;

   // Magnitudes, signs and the all-zero check
   function automatic lane_type abs_fn(cvec_type v, side_type s);
      lane_type a;
      logic [CROSS_W-1:0] orv;
      a = '0;
      a.side = s;
      for (int i = 0; i < 3; i++) begin
         a.neg[i] = v[i][CROSS_W-1];
         a.mag[i] = v[i][CROSS_W-1] ? (~v[i] + CROSS_W'(1)) : v[i];
      end
      orv = a.mag[0] | a.mag[1] | a.mag[2];
      a.zero = (orv == '0);
      return a;
   endfunction

   // One step of the leading-one alignment
   function automatic lane_type nrm_fn(lane_type a, int sh);
      logic [CROSS_W-1:0] orv;
      orv = a.mag[0] | a.mag[1] | a.mag[2];
      if ((orv >> (CROSS_W - sh)) == '0) begin
         for (int i = 0; i < 3; i++)
            a.mag[i] = a.mag[i] << sh;
      end
      return a;
   endfunction

   function automatic lane_type sqr_fn(lane_type a);
      logic [MW-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m = a.mag[i][CROSS_W-1 -: MW];
         a.sq[i] = SQ_W'(m) * SQ_W'(m);
      end
      return a;
   endfunction

   function automatic lane_type sum_fn(lane_type a);
      a.sum  = SUM_W'(a.sq[0]) + SUM_W'(a.sq[1]) + SUM_W'(a.sq[2]);
      a.srem = '0;
      a.root = '0;
      return a;
   endfunction

   // Two digit pairs of the integer square root
   function automatic lane_type sqt_fn(lane_type a, int p_hi);
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      int p;
      for (int k = 0; k < 2; k++) begin
         p = p_hi - k;
         if (p >= 0) begin
            rem2  = {a.srem[REM_W-3:0], a.sum[2*p +: 2]};
            trial = REM_W'({a.root, 2'b01});
            if (rem2 >= trial) begin
               a.srem = rem2 - trial;
               a.root = {a.root[ROOT_W-2:0], 1'b1};
            end else begin
               a.srem = rem2;
               a.root = {a.root[ROOT_W-2:0], 1'b0};
            end
         end
      end
      return a;
   endfunction

   // Dividend with half the length added for rounding
   function automatic lane_type pre_fn(lane_type a);
      logic [ROOT_W-1:0] half;
      half = a.root >> 1;
      for (int i = 0; i < 3; i++) begin
         a.num[i]  = NUM_W'({a.mag[i][CROSS_W-1 -: MW], {FRAC_BITS{1'b0}}}) + NUM_W'(half);
         a.drem[i] = DREM_W'(a.num[i] >> QUO_W);
         a.quo[i]  = '0;
      end
      return a;
   endfunction

   // Two quotient bits per lane
   function automatic lane_type div_fn(lane_type a, int b_hi);
      logic [DREM_W-1:0] r;
      int b;
      for (int k = 0; k < 2; k++) begin
         b = b_hi - k;
         if (b >= 0) begin
            for (int i = 0; i < 3; i++) begin
               r = {a.drem[i][DREM_W-2:0], a.num[i][b]};
               if (r >= DREM_W'(a.root)) begin
                  r = r - DREM_W'(a.root);
                  a.quo[i][b] = 1'b1;
               end
               a.drem[i] = r;
            end
         end
      end
      return a;
   endfunction

   function automatic lane_type fin_fn(lane_type a);
      for (int i = 0; i < 3; i++)
         a.u[i] = a.neg[i] ? (UNIT_W'(0) - UNIT_W'(a.quo[i])) : UNIT_W'(a.quo[i]);
      return a;
   endfunction

   lane_type           st_in [N_STG];
   lane_type           st_ff [N_STG];
   logic [N_STG-1:0]   vld_ff;

   assign st_in[0] = abs_fn(in_vec, in_side);

   // Stage functions along the pipe
   for (genvar k = 1; k < N_STG; k++) begin : g_stg
      if (k < S_SQR) begin : g_nrm
         assign st_in[k] = nrm_fn(st_ff[k-1], 1 << (NRM_STG - k));
      end else if (k == S_SQR) begin : g_sqr
         assign st_in[k] = sqr_fn(st_ff[k-1]);
      end else if (k == S_SUM) begin : g_sum
         assign st_in[k] = sum_fn(st_ff[k-1]);
      end else if (k < S_PRE) begin : g_sqt
         assign st_in[k] = sqt_fn(st_ff[k-1], ROOT_W - 1 - 2 * (k - S_SQT));
      end else if (k == S_PRE) begin : g_pre
         assign st_in[k] = pre_fn(st_ff[k-1]);
      end else if (k < S_FIN) begin : g_div
         assign st_in[k] = div_fn(st_ff[k-1], FRAC_BITS - 2 * (k - S_DIV));
      end else begin : g_fin
         assign st_in[k] = fin_fn(st_ff[k-1]);
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[N_STG-2:0], in_valid};
   end

   // Data stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N_STG; k++)
            st_ff[k] <= st_in[k];
      end
   end

   assign out_valid = vld_ff[N_STG-1];
   assign out_vec   = st_ff[N_STG-1].u;
   assign out_zero  = st_ff[N_STG-1].zero;
   assign out_side  = st_ff[N_STG-1].side;

endmodule

// ----- rtl/lav_cross.sv -----
`timescale 1ns / 1ps
module lav_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  lav_pkg::uvec_type  in_a,
   input  lav_pkg::wvec_type  in_b,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::cvec_type  out_vec,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   wide_type   prod_in [6];
   wide_type   prod_ff [6];
   side_type   side_ff;
   logic [1:0] vld_ff;

   // Six partial products: a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
   always_comb begin
      prod_in[0] = CROSS_W'($signed(in_a[1])) * CROSS_W'($signed(in_b[2]));
      prod_in[1] = CROSS_W'($signed(in_a[2])) * CROSS_W'($signed(in_b[1]));
      prod_in[2] = CROSS_W'($signed(in_a[2])) * CROSS_W'($signed(in_b[0]));
      prod_in[3] = CROSS_W'($signed(in_a[0])) * CROSS_W'($signed(in_b[2]));
      prod_in[4] = CROSS_W'($signed(in_a[0])) * CROSS_W'($signed(in_b[1]));
      prod_in[5] = CROSS_W'($signed(in_a[1])) * CROSS_W'($signed(in_b[0]));
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++)
            prod_ff[i] <= prod_in[i];
         side_ff <= in_side;
         out_side <= side_ff;
         out_vec[0] <= prod_ff[0] - prod_ff[1];
         out_vec[1] <= prod_ff[2] - prod_ff[3];
         out_vec[2] <= prod_ff[4] - prod_ff[5];
      end
   end

   assign out_valid = vld_ff[1];

endmodule

// ----- rtl/lav_dot.sv -----
`timescale 1ns / 1ps
module lav_dot (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  lav_pkg::side_type  in_side,
   input  lav_pkg::uvec_type  in_t,
   output logic               out_valid,
   output lav_pkg::mat_type   out_rows,
   output logic               out_deg
);
   import lav_pkg::*;

   typedef logic signed [DOT_W-1:0] dsum_type;

   // Scale back, round half away from zero, optional negate, saturate
   function automatic word_type col3_fn(dsum_type s, logic flip);
      logic [DOT_W-1:0] m;
      dsum_type         v;
      m = s[DOT_W-1] ? DOT_W'(-s) : DOT_W'(s);
      m = (m + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      v = (s[DOT_W-1] ^ flip) ? -$signed(m) : $signed(m);
      if (v[DOT_W-1:WORD_W-1] == '0 || v[DOT_W-1:WORD_W-1] == '1)
         return v[WORD_W-1:0];
      return v[DOT_W-1] ? WORD_MIN : WORD_MAX;
   endfunction

   uvec_type   src [3];
   uvec_type   rot_in [3];
   wide_type   prod_in [3][3];
   wide_type   prod_ff [3][3];
   uvec_type   rot1_ff [3];
   uvec_type   rot2_ff [3];
   dsum_type   sum_ff [3];
   logic       deg1_ff;
   logic       deg2_ff;
   logic [2:0] vld_ff;

   // Products of r, t and f with eye, and the rotation rows r, t and -f
   always_comb begin
      src[0] = in_side.r;
      src[1] = in_t;
      src[2] = in_side.f;
      rot_in[0] = in_side.r;
      rot_in[1] = in_t;
      for (int i = 0; i < 3; i++)
         rot_in[2][i] = UNIT_W'(0) - in_side.f[i];
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            prod_in[k][i] = CROSS_W'($signed(src[k][i])) * CROSS_W'($signed(in_side.eye[i]));
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         rot1_ff <= rot_in;
         deg1_ff <= in_side.deg;
         for (int k = 0; k < 3; k++)
            sum_ff[k] <= DOT_W'(prod_ff[k][0]) + DOT_W'(prod_ff[k][1])
                         + DOT_W'(prod_ff[k][2]);
         rot2_ff <= rot1_ff;
         deg2_ff <= deg1_ff;
         // Final rows, identity when degenerate
         out_deg <= deg2_ff;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               if (deg2_ff)
                  out_rows[k][j] <= (j == k) ? WORD_ONE : '0;
               else
                  out_rows[k][j] <= WORD_W'($signed(rot2_ff[k][j]));
            end
            out_rows[k][3] <= deg2_ff ? '0 : col3_fn(sum_ff[k], k < 2);
         end
      end
   end

   assign out_valid = vld_ff[2];

endmodule

// ----- rtl/lav_rows.sv -----
`timescale 1ns / 1ps
module lav_rows (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lav_pkg::mat_type  in_rows,
   input  logic              in_deg,
   output logic              in_stall,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [1:0]        out_row_index,
   output lav_pkg::word_type out_col0,
   output lav_pkg::word_type out_col1,
   output lav_pkg::word_type out_col2,
   output lav_pkg::word_type out_col3,
   output logic              out_degenerate,
   output logic              out_last_row
);
   import lav_pkg::*;

   logic       vld_ff, vld_in;
   logic [1:0] idx_ff, idx_in;
   mat_type    rows_ff, rows_in;
   logic       deg_ff, deg_in;
   logic       acc;
   logic       take;

   // Load a new matrix when empty or once the last row has gone out
   always_comb begin
      acc     = vld_ff && !out_stall;
      take    = !vld_ff || (acc && idx_ff == ROW_LAST);
      vld_in  = vld_ff;
      idx_in  = idx_ff;
      rows_in = rows_ff;
      deg_in  = deg_ff;
      if (take) begin
         vld_in  = in_valid;
         idx_in  = ROW_FIRST;
         rows_in = in_rows;
         deg_in  = in_deg;
      end else if (acc) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= ROW_FIRST;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      deg_ff  <= deg_in;
   end

   assign in_stall       = !take;
   assign out_valid      = vld_ff;
   assign out_row_index  = idx_ff;
   assign out_col0       = rows_ff[idx_ff][0];
   assign out_col1       = rows_ff[idx_ff][1];
   assign out_col2       = rows_ff[idx_ff][2];
   assign out_col3       = rows_ff[idx_ff][3];
   assign out_degenerate = deg_ff;
   assign out_last_row   = (idx_ff == ROW_LAST);

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// From an accepted request to its first row (FRAC_BITS 16) the path runs through three
//    normalize units of 36 stages, two cross stages each, and three dot stages.
// A new request can enter while earlier ones are in flight; the single result port sends three rows.
// A row stall freezes the whole pipe while a finished matrix waits at its end; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and the row index; no other state.
`timescale 1ns / 1ps
module look_at_view_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lav_pkg::word_type req_eye_x,
   input  lav_pkg::word_type req_eye_y,
   input  lav_pkg::word_type req_eye_z,
   input  lav_pkg::word_type req_target_x,
   input  lav_pkg::word_type req_target_y,
   input  lav_pkg::word_type req_target_z,
   input  lav_pkg::word_type req_up_x,
   input  lav_pkg::word_type req_up_y,
   input  lav_pkg::word_type req_up_z,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_row_index,
   output lav_pkg::word_type rsp_col0,
   output lav_pkg::word_type rsp_col1,
   output lav_pkg::word_type rsp_col2,
   output lav_pkg::word_type rsp_col3,
   output logic              rsp_degenerate,
   output logic              rsp_last_row
);
   import lav_pkg::*;

   logic     en;
   side_type side0, side1, side1m, side2, side3, side3m, side4, side4m, side5;
   cvec_type dvec, cvec1, cvec2;
   uvec_type fvec, rvec, tvec;
   wvec_type fb;
   logic     v1, v2, v3, v4, v5, v6;
   logic     z1, z3, z5;
   mat_type  rows;
   logic     rows_deg;
   logic     rows_stall;

   assign en        = !(v6 && rows_stall);
   assign req_stall = !en;

   // Request into the pipe
   always_comb begin
      side0.eye = {req_eye_z, req_eye_y, req_eye_x};
      side0.up  = {req_up_z, req_up_y, req_up_x};
      side0.f   = '0;
      side0.r   = '0;
      side0.deg = 1'b0;
      dvec[0] = CROSS_W'(req_target_x) - CROSS_W'(req_eye_x);
      dvec[1] = CROSS_W'(req_target_y) - CROSS_W'(req_eye_y);
      dvec[2] = CROSS_W'(req_target_z) - CROSS_W'(req_eye_z);
   end

   // Forward vector
   lav_unit u_fwd (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_vec(dvec), .in_side(side0),
      .out_valid(v1), .out_vec(fvec), .out_zero(z1), .out_side(side1)
   );

   always_comb begin
      side1m     = side1;
      side1m.f   = fvec;
      side1m.deg = side1.deg | z1;
   end

   lav_cross u_cross_fu (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v1), .in_a(side1m.f), .in_b(side1m.up), .in_side(side1m),
      .out_valid(v2), .out_vec(cvec1), .out_side(side2)
   );

   // Right vector
   lav_unit u_right (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v2), .in_vec(cvec1), .in_side(side2),
      .out_valid(v3), .out_vec(rvec), .out_zero(z3), .out_side(side3)
   );

   always_comb begin
      side3m     = side3;
      side3m.r   = rvec;
      side3m.deg = side3.deg | z3;
      for (int i = 0; i < 3; i++)
         fb[i] = WORD_W'($signed(side3m.f[i]));
   end

   lav_cross u_cross_rf (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v3), .in_a(side3m.r), .in_b(fb), .in_side(side3m),
      .out_valid(v4), .out_vec(cvec2), .out_side(side4)
   );

   // True up vector
   lav_unit u_true_up (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4), .in_vec(cvec2), .in_side(side4),
      .out_valid(v5), .out_vec(tvec), .out_zero(z5), .out_side(side5)
   );

   always_comb begin
      side4m     = side5;
      side4m.deg = side5.deg | z5;
   end

   lav_dot u_dot (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v5), .in_side(side4m), .in_t(tvec),
      .out_valid(v6), .out_rows(rows), .out_deg(rows_deg)
   );

   lav_rows u_rows (
      .clock(clock), .reset(reset),
      .in_valid(v6), .in_rows(rows), .in_deg(rows_deg), .in_stall(rows_stall),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_row_index(rsp_row_index),
      .out_col0(rsp_col0), .out_col1(rsp_col1), .out_col2(rsp_col2), .out_col3(rsp_col3),
      .out_degenerate(rsp_degenerate), .out_last_row(rsp_last_row)
   );

`ifndef SYNTH
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && (rsp_row_index == $past(rsp_row_index) + 2'd1))
      else $error("row sequence broken");

   a_deg_trans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_col3 == '0)
      else $error("degenerate row with translation");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_col0) <= WORD_ONE) && ($signed(rsp_col0) >= -WORD_ONE))
      else $error("rotation entry out of unit range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_row == (rsp_row_index == ROW_LAST))
      else $error("last row flag mismatch");
`endif

endmodule

// ----- test/look_at_view_matrix_tb.sv -----
`timescale 1ns / 1ps
module look_at_view_matrix_tb;
   import lav_pkg::*;

   localparam int N_RANDOM   = 360;
   localparam int DRAIN_WAIT = 300;

   typedef struct {
      logic [1:0] row;
      word_type   c0, c1, c2, c3;
      logic       deg;
      logic       last;
   } row_rsp_type;

   typedef struct {
      word_type eye[3];
      word_type tgt[3];
      word_type up[3];
      bit       typed;   // identity rows typed in by hand
   } view_req_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   word_type req_target_x = '0, req_target_y = '0, req_target_z = '0;
   word_type req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   word_type rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic     rsp_degenerate, rsp_last_row;

   row_rsp_type expected_rows[$];
   int  n_errors = 0;
   bit  quiet_rsp = 0;

   look_at_view_matrix uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---- fixed point view math ----
   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res = 0, bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   // returns 1 on zero length
   function automatic bit to_unit(input longint v[3], output longint u[3]);
      longint unsigned mag[3], top = 0, sq, len, q;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
         if (mag[i] > top) top = mag[i];
      end
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (top == 0) return 1;
      while (top >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
         top >>= 1;
      end
      while (top < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
         top <<= 1;
      end
      sq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = root64(sq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 0;
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint c[3]);
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
   endfunction

   // dot with eye, shifted back, ties away from zero, optional negate, saturated
   function automatic word_type eye_offset(longint a[3], longint e[3], bit neg);
      longint s = a[0]*e[0] + a[1]*e[1] + a[2]*e[2];
      longint unsigned m = s < 0 ? 64'd0 - longint'(s) : s;
      longint res;
      m = (m + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
      res = s < 0 ? -longint'(m) : longint'(m);
      if (neg) res = -res;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return word_type'(res);
   endfunction

   function automatic void push_identity();
      for (int k = 0; k < 3; k++) begin
         row_rsp_type e;
         e.row = 2'(k);
         e.c0 = k == 0 ? WORD_ONE : '0;
         e.c1 = k == 1 ? WORD_ONE : '0;
         e.c2 = k == 2 ? WORD_ONE : '0;
         e.c3 = '0;
         e.deg = 1'b1;
         e.last = 2'(k) == ROW_LAST;
         expected_rows.push_back(e);
      end
   endfunction

   function automatic void predict_view(view_req_type q);
      longint eye[3], d[3], f[3], r[3], t[3], tmp[3], up[3];
      bit deg;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'(q.eye[i]);
         up[i] = longint'(q.up[i]);
         d[i] = longint'(q.tgt[i]) - eye[i];
      end
      deg = to_unit(d, f);
      if (!deg) begin
         cross_prod(f, up, tmp);
         deg = to_unit(tmp, r);
      end
      if (!deg) begin
         cross_prod(r, f, tmp);
         deg = to_unit(tmp, t);
      end
      if (deg) begin
         push_identity();
      end else begin
         row_rsp_type e;
         e.deg = 1'b0;
         e.row = ROW_FIRST; e.last = 1'b0;
         e.c0 = word_type'(r[0]); e.c1 = word_type'(r[1]); e.c2 = word_type'(r[2]);
         e.c3 = eye_offset(r, eye, 1);
         expected_rows.push_back(e);
         e.row = 2'd1;
         e.c0 = word_type'(t[0]); e.c1 = word_type'(t[1]); e.c2 = word_type'(t[2]);
         e.c3 = eye_offset(t, eye, 1);
         expected_rows.push_back(e);
         e.row = ROW_LAST; e.last = 1'b1;
         e.c0 = word_type'(-f[0]); e.c1 = word_type'(-f[1]); e.c2 = word_type'(-f[2]);
         e.c3 = eye_offset(f, eye, 0);
         expected_rows.push_back(e);
      end
   endfunction

   // ---- stimulus helpers ----
   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3, 4: return word_type'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic view_req_type make_req(word_type ex, word_type ey, word_type ez,
                                             word_type tx, word_type ty, word_type tz,
                                             word_type ux, word_type uy, word_type uz,
                                             bit typed);
      view_req_type q;
      q.eye = '{ex, ey, ez};
      q.tgt = '{tx, ty, tz};
      q.up = '{ux, uy, uz};
      q.typed = typed;
      return q;
   endfunction

   function automatic view_req_type rand_req();
      view_req_type q;
      for (int i = 0; i < 3; i++) begin
         q.eye[i] = rand_word();
         q.tgt[i] = rand_word();
         q.up[i] = rand_word();
      end
      q.typed = 0;
      case ($urandom_range(0, 19))
         0: q.tgt = q.eye;                 // no forward direction
         1: q.up = '{0, 0, 0};              // zero up vector
         2: for (int i = 0; i < 3; i++)     // up parallel to forward
               q.up[i] = q.tgt[i] - q.eye[i];
         default: ;
      endcase
      return q;
   endfunction

   // valid drops only while idling, so back to back requests keep it high
   task automatic send_req(view_req_type q, bit gaps);
      while (gaps && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_eye_x, req_eye_y, req_eye_z} <= {q.eye[0], q.eye[1], q.eye[2]};
      {req_target_x, req_target_y, req_target_z} <= {q.tgt[0], q.tgt[1], q.tgt[2]};
      {req_up_x, req_up_y, req_up_z} <= {q.up[0], q.up[1], q.up[2]};
      if (q.typed) push_identity();
      else predict_view(q);
      do @(posedge clock); while (req_stall);
   endtask

   // ---- result side: random stall, check against oldest expectation ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected row %0d col0 %h", $time, rsp_row_index, rsp_col0);
               n_errors++;
            end else begin
               row_rsp_type e;
               e = expected_rows.pop_front();
               if (rsp_row_index !== e.row || rsp_col0 !== e.c0 || rsp_col1 !== e.c1 ||
                   rsp_col2 !== e.c2 || rsp_col3 !== e.c3 ||
                   rsp_degenerate !== e.deg || rsp_last_row !== e.last) begin
                  $display("%0t: mismatch expected row %0d %h %h %h %h deg %b last %b",
                           $time, e.row, e.c0, e.c1, e.c2, e.c3, e.deg, e.last);
                  $display("%0t:            actual row %0d %h %h %h %h deg %b last %b",
                           $time, rsp_row_index, rsp_col0, rsp_col1, rsp_col2, rsp_col3,
                           rsp_degenerate, rsp_last_row);
                  n_errors++;
               end
            end
         end
         rsp_stall <= !quiet_rsp && ($urandom_range(0, 99) < 18);
      end
   end

   // ---- main sequence ----
   view_req_type directed[$];

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate cases with identity rows typed in
      directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, WORD_ONE, 0, 1));
      directed.push_back(make_req(WORD_MAX, WORD_MIN, 5, WORD_MAX, WORD_MIN, 5,
                                  0, WORD_ONE, 0, 1));
      directed.push_back(make_req(0, 0, 0, 0, 0, -WORD_ONE, 0, 0, 0, 1));
      directed.push_back(make_req(0, 0, 0, 0, WORD_ONE, 0, 0, WORD_MAX, 0, 1));
      directed.push_back(make_req(WORD_ONE, 0, 0, 0, 0, 0, WORD_MIN, 0, 0, 1));
      // ordinary views and field extremes
      directed.push_back(make_req(0, 0, 5*WORD_ONE, 0, 0, 0, 0, WORD_ONE, 0, 0));
      directed.push_back(make_req(WORD_ONE, 2*WORD_ONE, 3*WORD_ONE, 0, 0, 0,
                                  0, WORD_ONE, 0, 0));
      directed.push_back(make_req(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX,
                                  WORD_MAX, WORD_MIN, 0, WORD_MAX, 0));
      directed.push_back(make_req(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN,
                                  WORD_MIN, WORD_MAX, WORD_MIN, 0, 0));
      directed.push_back(make_req(WORD_MAX, WORD_MIN, WORD_MAX, 0, 0, 0,
                                  1, -1, 1, 0));
      directed.push_back(make_req(-1, -1, -1, 0, 0, 0, -1, 0, 1, 0));
      directed.push_back(make_req(WORD_MIN, 0, 0, WORD_MAX, 1, 0, 0, 0, -1, 0));
      directed.push_back(make_req(0, WORD_MAX, 0, 1, 0, 0, WORD_MIN, WORD_MIN,
                                  WORD_MIN, 0));
      directed.push_back(make_req(32'h12345678, 32'hDEADBEEF, 32'h0F0F0F0F,
                                  32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA,
                                  32'h33333333, 32'hCCCCCCCC, 32'h00010000, 0));
      foreach (directed[i]) send_req(directed[i], 1);
      req_valid <= 1'b0;

      // sender holds off until every row has come back
      while (expected_rows.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         // a stretch with no idling on either side
         quiet_rsp <= (n >= 150 && n < 220);
         send_req(rand_req(), !(n >= 150 && n < 220));
      end
      req_valid <= 1'b0;
      quiet_rsp <= 1'b0;

      while (expected_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_errors == 0 && expected_rows.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("%0t: timeout, %0d rows still expected", $time, expected_rows.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- look_at_view_matrix.f -----
rtl/lav_pkg.sv
rtl/lav_unit.sv
rtl/lav_cross.sv
rtl/lav_dot.sv
rtl/lav_rows.sv
rtl/look_at_view_matrix.sv
test/look_at_view_matrix_tb.sv
